// ===== sv/rvc_pkg.sv =====
// ----------------------------------------------------------------------------
// rvc_pkg
// Shared types, opcodes and sizes of the RV32I multicycle integer core.
// ----------------------------------------------------------------------------
package rvc_pkg;

	localparam int MEM_ADDR_W = 18;
	localparam int MEM_BYTES  = 1 << MEM_ADDR_W;
	localparam int NUM_REGS   = 32;
	localparam int REG_IDX_W  = 5;
	localparam int HALT_W     = 18;
	localparam logic [HALT_W-1:0] HALT_RESET = 18'h30004;
	localparam logic [REG_IDX_W-1:0] EXIT_REG = 5'd10;

	localparam logic [6:0] OP_LUI    = 7'h37;
	localparam logic [6:0] OP_AUIPC  = 7'h17;
	localparam logic [6:0] OP_JAL    = 7'h6F;
	localparam logic [6:0] OP_JALR   = 7'h67;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_LOAD   = 7'h03;
	localparam logic [6:0] OP_STORE  = 7'h23;
	localparam logic [6:0] OP_IMM    = 7'h13;
	localparam logic [6:0] OP_REG    = 7'h33;

	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	localparam logic [2:0] F3_LB  = 3'd0;
	localparam logic [2:0] F3_LH  = 3'd1;
	localparam logic [2:0] F3_LW  = 3'd2;
	localparam logic [2:0] F3_LBU = 3'd4;
	localparam logic [2:0] F3_LHU = 3'd5;

	localparam logic [2:0] F3_SB = 3'd0;
	localparam logic [2:0] F3_SH = 3'd1;
	localparam logic [2:0] F3_SW = 3'd2;

	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;

	typedef struct packed {
		logic        mode;
		logic [17:0] load_address;
		logic [7:0]  load_byte;
	} in_t;

	typedef struct packed {
		logic [31:0] instr_pc;
		logic [31:0] next_pc;
		logic        reg_written;
		logic [4:0]  reg_index;
		logic [31:0] reg_value;
		logic        halted;
		logic [7:0]  exit_code;
	} out_t;

	typedef struct packed {
		logic accept;
		logic accept_load;
		logic fetch;
		logic rs1;
		logic rs2;
		logic exec;
		logic mem;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic stopped;
		logic load_req;
		logic fetch_done;
		logic exec_mem;
		logic mem_done;
	} status_t;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_FETCH = 7'b0000010,
		ST_RS1   = 7'b0000100,
		ST_RS2   = 7'b0001000,
		ST_EXEC  = 7'b0010000,
		ST_MEM   = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

endpackage

// ===== sv/rv32i_integer_core.sv =====
// ----------------------------------------------------------------------------
// rv32i_integer_core
// RV32I multicycle integer core with byte-wide program memory.
// ----------------------------------------------------------------------------
// Each input word either loads one program byte (mode 0) or runs one
// instruction: the word is accepted, its four bytes are fetched through the
// single byte-wide memory port, rs1 and rs2 are read in turn from the
// one-read-port register file, then it executes and retires.
// Loads and stores add a memory step that moves their bytes one at a time.
// The result register lets the next word be taken while a result waits.
// A byte store to halt_address stops the core; later words only report.
// ----------------------------------------------------------------------------
module rv32i_integer_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  rvc_pkg::in_t               in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output rvc_pkg::out_t              out_data,
	input  logic                       cfg_wr_en,
	input  logic [rvc_pkg::HALT_W-1:0] cfg_wr_data
);

	rvc_pkg::cmd_t    cmd;
	rvc_pkg::status_t st;

	rvc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.st       (st),
		.cmd      (cmd)
	);

	rvc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.in_data    (in_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.out_data   (out_data)
	);

endmodule

// ===== sv/rvc_ram.sv =====
// ----------------------------------------------------------------------------
// rvc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rvc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/rvc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rvc_ctrl
// Instruction sequencer: steps each instruction through fetch, register read,
// execute, memory access and hand-off; byte-load and halted words skip to it.
// ----------------------------------------------------------------------------
module rvc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  rvc_pkg::status_t st,
	output rvc_pkg::cmd_t    cmd
);

	rvc_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic fire;

	assign in_ready  = (state_q == rvc_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign fire      = (state_q == rvc_pkg::ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		cmd             = '0;
		cmd.accept      = in_ready && in_valid;
		cmd.accept_load = cmd.accept && st.load_req && !st.stopped;
		cmd.fetch       = (state_q == rvc_pkg::ST_FETCH);
		cmd.rs1         = (state_q == rvc_pkg::ST_RS1);
		cmd.rs2         = (state_q == rvc_pkg::ST_RS2);
		cmd.exec        = (state_q == rvc_pkg::ST_EXEC);
		cmd.mem         = (state_q == rvc_pkg::ST_MEM);
		cmd.finish      = fire;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rvc_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = (st.stopped || st.load_req) ? rvc_pkg::ST_DONE : rvc_pkg::ST_FETCH;
				end
			end
			rvc_pkg::ST_FETCH: begin
				if (st.fetch_done) state_d = rvc_pkg::ST_RS1;
			end
			rvc_pkg::ST_RS1:  state_d = rvc_pkg::ST_RS2;
			rvc_pkg::ST_RS2:  state_d = rvc_pkg::ST_EXEC;
			rvc_pkg::ST_EXEC: state_d = st.exec_mem ? rvc_pkg::ST_MEM : rvc_pkg::ST_DONE;
			rvc_pkg::ST_MEM: begin
				if (st.mem_done) state_d = rvc_pkg::ST_DONE;
			end
			rvc_pkg::ST_DONE: begin
				if (fire) state_d = rvc_pkg::ST_IDLE;
			end
			default: state_d = rvc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rvc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/rvc_dp.sv =====
// ----------------------------------------------------------------------------
// rvc_dp
// Core datapath: program counter, register file, byte memory, ALU and
// result register.
// ----------------------------------------------------------------------------
module rvc_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rvc_pkg::cmd_t                cmd,
	output rvc_pkg::status_t             st,
	input  rvc_pkg::in_t                 in_data,
	input  logic                         cfg_wr_en,
	input  logic [rvc_pkg::HALT_W-1:0]   cfg_wr_data,
	output rvc_pkg::out_t                out_data
);

	logic [31:0] pc_q, npc_q, instr_q, a_q, b_q, val_q, ea_q, data_q;
	logic        wr_q, load_q, store_q, stopped_q;
	logic [2:0]  len_q, cnt_q;
	logic [7:0]  code_q, x10_q;
	logic [rvc_pkg::HALT_W-1:0] halt_q;
	logic [rvc_pkg::NUM_REGS-1:0] rv_q;
	rvc_pkg::out_t out_q;

	logic [rvc_pkg::MEM_ADDR_W-1:0] mem_addr, mem_waddr;
	logic [7:0]  mem_wdata, mem_rdata;
	logic        mem_we;
	logic [1:0]  cap_idx;
	logic [31:0] base;

	logic [rvc_pkg::REG_IDX_W-1:0] rs1, rs2, rd, rf_raddr;
	logic [31:0] rf_rdata, b_in;
	logic        fin_wr;
	logic [31:0] fin_val;

	logic [6:0]  op, f7;
	logic [2:0]  f3;
	logic [31:0] ii, si, bi, ji, up;
	logic [31:0] e_val, e_npc, e_ea, opb;
	logic        e_wr, e_load, e_store, e_halt, take;
	logic [2:0]  e_len;

	assign op  = instr_q[6:0];
	assign f3  = instr_q[14:12];
	assign f7  = instr_q[31:25];
	assign rd  = instr_q[11:7];
	assign rs1 = instr_q[19:15];
	assign rs2 = instr_q[24:20];
	assign ii  = {{20{instr_q[31]}}, instr_q[31:20]};
	assign si  = {{20{instr_q[31]}}, instr_q[31:25], instr_q[11:7]};
	assign bi  = {{19{instr_q[31]}}, instr_q[31], instr_q[7], instr_q[30:25],
		instr_q[11:8], 1'b0};
	assign ji  = {{11{instr_q[31]}}, instr_q[31], instr_q[19:12], instr_q[20],
		instr_q[30:21], 1'b0};
	assign up  = {instr_q[31:12], 12'h000};

	assign base      = cmd.fetch ? pc_q : ea_q;
	assign mem_addr  = base[rvc_pkg::MEM_ADDR_W-1:0] + rvc_pkg::MEM_ADDR_W'(cnt_q);
	assign mem_we    = cmd.accept_load || (cmd.mem && store_q && (cnt_q < len_q));
	assign mem_waddr = cmd.accept_load ?
		rvc_pkg::MEM_ADDR_W'(in_data.load_address) : mem_addr;
	assign mem_wdata = cmd.accept_load ? in_data.load_byte : b_q[8*cnt_q[1:0] +: 8];
	assign cap_idx   = 2'(cnt_q - 3'd1);

	rvc_ram #(
		.WIDTH(8),
		.DEPTH(rvc_pkg::MEM_BYTES)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_addr),
		.rdata(mem_rdata)
	);

	assign rf_raddr = cmd.rs1 ? rs1 : rs2;

	rvc_ram #(
		.WIDTH(32),
		.DEPTH(rvc_pkg::NUM_REGS)
	) u_rf (
		.clk  (clk),
		.we   (cmd.finish && fin_wr),
		.waddr(rd),
		.wdata(fin_val),
		.raddr(rf_raddr),
		.rdata(rf_rdata)
	);

	assign b_in = rv_q[rs2] ? rf_rdata : 32'd0;
	assign opb  = (op == rvc_pkg::OP_REG) ? b_in : ii;

	always_comb begin
		e_val   = 32'd0;
		e_npc   = pc_q + 32'd4;
		e_wr    = 1'b0;
		e_ea    = a_q + ii;
		e_load  = 1'b0;
		e_store = 1'b0;
		e_halt  = 1'b0;
		e_len   = 3'd0;
		take    = 1'b0;
		case (op)
			rvc_pkg::OP_LUI: begin
				e_wr  = 1'b1;
				e_val = up;
			end
			rvc_pkg::OP_AUIPC: begin
				e_wr  = 1'b1;
				e_val = pc_q + up;
			end
			rvc_pkg::OP_JAL: begin
				e_wr  = 1'b1;
				e_val = pc_q + 32'd4;
				e_npc = pc_q + ji;
			end
			rvc_pkg::OP_JALR: begin
				e_wr  = 1'b1;
				e_val = pc_q + 32'd4;
				e_npc = (a_q + ii) & 32'hFFFFFFFE;
			end
			rvc_pkg::OP_BRANCH: begin
				case (f3)
					rvc_pkg::F3_BEQ:  take = (a_q == b_in);
					rvc_pkg::F3_BNE:  take = (a_q != b_in);
					rvc_pkg::F3_BLT:  take = ($signed(a_q) < $signed(b_in));
					rvc_pkg::F3_BGE:  take = !($signed(a_q) < $signed(b_in));
					rvc_pkg::F3_BLTU: take = (a_q < b_in);
					rvc_pkg::F3_BGEU: take = (a_q >= b_in);
					default:          take = 1'b0;
				endcase
				if (take) e_npc = pc_q + bi;
			end
			rvc_pkg::OP_LOAD: begin
				e_load = 1'b1;
				e_wr   = 1'b1;
				case (f3)
					rvc_pkg::F3_LB, rvc_pkg::F3_LBU: e_len = 3'd1;
					rvc_pkg::F3_LH, rvc_pkg::F3_LHU: e_len = 3'd2;
					rvc_pkg::F3_LW:                  e_len = 3'd4;
					default: begin
						e_wr   = 1'b0;
						e_load = 1'b0;
					end
				endcase
			end
			rvc_pkg::OP_STORE: begin
				e_ea = a_q + si;
				case (f3)
					rvc_pkg::F3_SB: begin
						if (e_ea == 32'(halt_q)) begin
							e_halt = 1'b1;
						end else begin
							e_store = 1'b1;
							e_len   = 3'd1;
						end
					end
					rvc_pkg::F3_SH: begin
						e_store = 1'b1;
						e_len   = 3'd2;
					end
					rvc_pkg::F3_SW: begin
						e_store = 1'b1;
						e_len   = 3'd4;
					end
					default: e_len = 3'd0;
				endcase
			end
			rvc_pkg::OP_IMM, rvc_pkg::OP_REG: begin
				e_wr = 1'b1;
				case (f3)
					rvc_pkg::F3_ADD: begin
						if (op == rvc_pkg::OP_IMM || f7 == rvc_pkg::F7_BASE) begin
							e_val = a_q + opb;
						end else if (f7 == rvc_pkg::F7_ALT) begin
							e_val = a_q - opb;
						end else begin
							e_wr = 1'b0;
						end
					end
					rvc_pkg::F3_SLL:  e_val = a_q << opb[4:0];
					rvc_pkg::F3_SLT:  e_val = {31'd0, $signed(a_q) < $signed(opb)};
					rvc_pkg::F3_SLTU: e_val = {31'd0, a_q < opb};
					rvc_pkg::F3_XOR:  e_val = a_q ^ opb;
					rvc_pkg::F3_SR: begin
						if (f7 == rvc_pkg::F7_BASE) begin
							e_val = a_q >> opb[4:0];
						end else if (f7 == rvc_pkg::F7_ALT) begin
							e_val = 32'($signed(a_q) >>> opb[4:0]);
						end else begin
							e_wr = 1'b0;
						end
					end
					rvc_pkg::F3_OR:   e_val = a_q | opb;
					default:          e_val = a_q & opb;
				endcase
			end
			default: e_wr = 1'b0;
		endcase
	end

	always_comb begin
		fin_val = val_q;
		if (load_q) begin
			case (f3)
				rvc_pkg::F3_LB:  fin_val = {{24{data_q[7]}}, data_q[7:0]};
				rvc_pkg::F3_LH:  fin_val = {{16{data_q[15]}}, data_q[15:0]};
				rvc_pkg::F3_LBU: fin_val = {24'd0, data_q[7:0]};
				rvc_pkg::F3_LHU: fin_val = {16'd0, data_q[15:0]};
				default:         fin_val = data_q;
			endcase
		end
	end

	assign fin_wr = wr_q && (rd != '0);

	assign st.stopped    = stopped_q;
	assign st.load_req   = !in_data.mode;
	assign st.fetch_done = (cnt_q == 3'd4);
	assign st.exec_mem   = (e_len != 3'd0);
	assign st.mem_done   = (cnt_q == len_q);

	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= 32'd0;
			stopped_q <= 1'b0;
			code_q    <= 8'd0;
			x10_q     <= 8'd0;
			halt_q    <= rvc_pkg::HALT_RESET;
			rv_q      <= '0;
			cnt_q     <= 3'd0;
			len_q     <= 3'd0;
			wr_q      <= 1'b0;
			load_q    <= 1'b0;
			store_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) halt_q <= cfg_wr_data;
			if (cmd.accept) begin
				cnt_q  <= 3'd0;
				wr_q   <= 1'b0;
				load_q <= 1'b0;
			end
			if (cmd.fetch) begin
				cnt_q <= st.fetch_done ? 3'd0 : cnt_q + 3'd1;
			end
			if (cmd.exec) begin
				cnt_q   <= 3'd0;
				wr_q    <= e_wr;
				load_q  <= e_load;
				store_q <= e_store;
				len_q   <= e_len;
				if (e_halt) begin
					stopped_q <= 1'b1;
					code_q    <= x10_q;
				end
			end
			if (cmd.mem) cnt_q <= cnt_q + 3'd1;
			if (cmd.finish) begin
				pc_q <= npc_q;
				if (fin_wr) begin
					rv_q[rd] <= 1'b1;
					if (rd == rvc_pkg::EXIT_REG) x10_q <= fin_val[7:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) npc_q <= pc_q;
		if (cmd.fetch && cnt_q != 3'd0) instr_q[8*cap_idx +: 8] <= mem_rdata;
		if (cmd.rs2) a_q <= rv_q[rs1] ? rf_rdata : 32'd0;
		if (cmd.exec) begin
			b_q   <= b_in;
			val_q <= e_val;
			npc_q <= e_npc;
			ea_q  <= e_ea;
		end
		if (cmd.mem && !store_q && cnt_q != 3'd0) data_q[8*cap_idx +: 8] <= mem_rdata;
		if (cmd.finish) begin
			out_q.instr_pc    <= pc_q;
			out_q.next_pc     <= npc_q;
			out_q.reg_written <= fin_wr;
			out_q.reg_index   <= fin_wr ? rd : '0;
			out_q.reg_value   <= fin_wr ? fin_val : 32'd0;
			out_q.halted      <= stopped_q;
			out_q.exit_code   <= code_q;
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RV32I multicycle integer core.
// ----------------------------------------------------------------------------
// Loads program bytes and steps instructions through the input channel. An
// in-bench core model or a directed row gives each result word, which is
// checked field by field. A directed walk covers every opcode and corner case,
// then random runs use four halt addresses; the last ends on a halting SB.
// Every fetch and load touches only bytes that were written first.
// ----------------------------------------------------------------------------
module tb;
	import rvc_pkg::*;

	localparam int DRAIN_CYC = 40;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	in_t               in_data = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_t              out_data;
	logic              cfg_wr_en = 1'b0;
	logic [HALT_W-1:0] cfg_wr_data = '0;

	rv32i_integer_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// core model state
	logic [7:0]        mem_b  [0:MEM_BYTES-1];
	bit                mem_ok [0:MEM_BYTES-1];
	logic [31:0]       regs   [0:NUM_REGS-1];
	logic [31:0]       core_pc = '0;
	logic              core_stop = 1'b0;
	logic [7:0]        core_code = '0;
	logic [HALT_W-1:0] core_halt = HALT_RESET;

	out_t result_q[$];
	int   err_cnt = 0;
	int   rx_cnt = 0;
	int   sent = 0;
	int   burst_left = 0;

	typedef struct {
		logic [31:0] word;
		bit          typed;
		out_t        res;
	} dir_row_t;

	typedef bit bool_ok_t;

	dir_row_t dir_rows[$];

	function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
		logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
		return {f7, rs2, rs1, f3, rd, op};
	endfunction

	function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
		logic [4:0] rd, logic [6:0] op);
		return {imm, rs1, f3, rd, op};
	endfunction

	function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
		logic [2:0] f3);
		return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
	endfunction

	function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
		logic [2:0] f3);
		return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
	endfunction

	function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
		return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
	endfunction

	function automatic logic [31:0] enc_u(logic [19:0] imm, logic [4:0] rd, logic [6:0] op);
		return {imm, rd, op};
	endfunction

	function automatic out_t mk_out(logic [31:0] pc, logic [31:0] npc, logic wr,
		logic [4:0] idx, logic [31:0] val);
		out_t r;
		r = '0;
		r.instr_pc = pc;
		r.next_pc = npc;
		r.reg_written = wr;
		r.reg_index = idx;
		r.reg_value = val;
		return r;
	endfunction

	function automatic logic [31:0] mem_rd(logic [31:0] a, int n);
		logic [31:0] v;
		logic [31:0] t;
		v = '0;
		for (int i = n - 1; i >= 0; i--) begin
			t = a + i;
			v = (v << 8) | 32'(mem_b[t[MEM_ADDR_W-1:0]]);
		end
		return v;
	endfunction

	function automatic void mem_wr(logic [31:0] a, logic [31:0] v, int n);
		logic [31:0] t;
		for (int i = 0; i < n; i++) begin
			t = a + i;
			mem_b[t[MEM_ADDR_W-1:0]] = v[7:0];
			mem_ok[t[MEM_ADDR_W-1:0]] = 1'b1;
			v = v >> 8;
		end
	endfunction

	function automatic out_t core_step(in_t w);
		logic [31:0] pc, npc, c, a, b, ii, si, bi, ji, ea, val;
		logic [4:0]  rd;
		logic [6:0]  op, f7;
		logic [2:0]  f3;
		logic        wr, take;
		out_t        r;
		pc = core_pc;
		npc = pc;
		wr = 1'b0;
		rd = '0;
		val = '0;
		if (!core_stop && !w.mode) begin
			mem_b[w.load_address] = w.load_byte;
			mem_ok[w.load_address] = 1'b1;
		end else if (!core_stop) begin
			c = mem_rd(pc, 4);
			op = c[6:0];
			f3 = c[14:12];
			f7 = c[31:25];
			a = regs[c[19:15]];
			b = regs[c[24:20]];
			ii = {{20{c[31]}}, c[31:20]};
			si = {{20{c[31]}}, c[31:25], c[11:7]};
			bi = {{19{c[31]}}, c[31], c[7], c[30:25], c[11:8], 1'b0};
			ji = {{11{c[31]}}, c[31], c[19:12], c[20], c[30:21], 1'b0};
			rd = c[11:7];
			npc = pc + 4;
			case (op)
				OP_LUI: begin
					wr = 1'b1;
					val = {c[31:12], 12'h0};
				end
				OP_AUIPC: begin
					wr = 1'b1;
					val = pc + {c[31:12], 12'h0};
				end
				OP_JAL: begin
					wr = 1'b1;
					val = pc + 4;
					npc = pc + ji;
				end
				OP_JALR: begin
					wr = 1'b1;
					val = pc + 4;
					npc = (a + ii) & 32'hFFFF_FFFE;
				end
				OP_BRANCH: begin
					case (f3)
						F3_BEQ:  take = (a == b);
						F3_BNE:  take = (a != b);
						F3_BLT:  take = ($signed(a) < $signed(b));
						F3_BGE:  take = !($signed(a) < $signed(b));
						F3_BLTU: take = (a < b);
						F3_BGEU: take = (a >= b);
						default: take = 1'b0;
					endcase
					if (take)
						npc = pc + bi;
				end
				OP_LOAD: begin
					ea = a + ii;
					wr = 1'b1;
					case (f3)
						F3_LB: begin
							val = mem_rd(ea, 1);
							val = {{24{val[7]}}, val[7:0]};
						end
						F3_LH: begin
							val = mem_rd(ea, 2);
							val = {{16{val[15]}}, val[15:0]};
						end
						F3_LW:   val = mem_rd(ea, 4);
						F3_LBU:  val = mem_rd(ea, 1);
						F3_LHU:  val = mem_rd(ea, 2);
						default: wr = 1'b0;
					endcase
				end
				OP_STORE: begin
					ea = a + si;
					if (f3 == F3_SB) begin
						if (ea == {14'h0, core_halt}) begin
							core_code = regs[EXIT_REG][7:0];
							core_stop = 1'b1;
						end else begin
							mem_wr(ea, b, 1);
						end
					end else if (f3 == F3_SH) begin
						mem_wr(ea, b, 2);
					end else if (f3 == F3_SW) begin
						mem_wr(ea, b, 4);
					end
				end
				OP_IMM: begin
					wr = 1'b1;
					case (f3)
						F3_ADD:  val = a + ii;
						F3_SLL:  val = a << ii[4:0];
						F3_SLT:  val = ($signed(a) < $signed(ii)) ? 32'd1 : 32'd0;
						F3_SLTU: val = (a < ii) ? 32'd1 : 32'd0;
						F3_XOR:  val = a ^ ii;
						F3_SR: begin
							if (f7 == F7_BASE)
								val = a >> ii[4:0];
							else if (f7 == F7_ALT)
								val = $signed(a) >>> ii[4:0];
							else
								wr = 1'b0;
						end
						F3_OR:   val = a | ii;
						default: val = a & ii;
					endcase
				end
				OP_REG: begin
					wr = 1'b1;
					case (f3)
						F3_ADD: begin
							if (f7 == F7_BASE)
								val = a + b;
							else if (f7 == F7_ALT)
								val = a - b;
							else
								wr = 1'b0;
						end
						F3_SLL:  val = a << b[4:0];
						F3_SLT:  val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
						F3_SLTU: val = (a < b) ? 32'd1 : 32'd0;
						F3_XOR:  val = a ^ b;
						F3_SR: begin
							if (f7 == F7_BASE)
								val = a >> b[4:0];
							else if (f7 == F7_ALT)
								val = $signed(a) >>> b[4:0];
							else
								wr = 1'b0;
						end
						F3_OR:   val = a | b;
						default: val = a & b;
					endcase
				end
				default: ;
			endcase
			if (wr && rd != 0)
				regs[rd] = val;
			else
				wr = 1'b0;
			core_pc = npc;
		end
		if (!wr) begin
			rd = '0;
			val = '0;
		end
		r.instr_pc = pc;
		r.next_pc = npc;
		r.reg_written = wr;
		r.reg_index = rd;
		r.reg_value = val;
		r.halted = core_stop;
		r.exit_code = core_code;
		return r;
	endfunction

	task automatic push_word(in_t w, bit typed = 1'b0, out_t typed_res = '0);
		out_t e;
		int   gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		e = core_step(w);
		result_q.push_back(typed ? typed_res : e);
		sent++;
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic put_byte(logic [31:0] a, logic [7:0] v);
		in_t w;
		w.mode = 1'b0;
		w.load_address = a[MEM_ADDR_W-1:0];
		w.load_byte = v;
		push_word(w);
	endtask

	task automatic exec_one(logic [31:0] word, bit fresh, bit may_halt,
		bit typed = 1'b0, out_t typed_res = '0);
		logic [31:0] c, ea, t;
		int          n;
		in_t         w;
		if (fresh)
			for (int i = 0; i < 4; i++)
				put_byte(core_pc + i, word[8*i +: 8]);
		c = mem_rd(core_pc, 4);
		if (c[6:0] == OP_STORE && c[14:12] == F3_SB && !may_halt) begin
			ea = regs[c[19:15]] + {{20{c[31]}}, c[31:25], c[11:7]};
			if (ea == {14'h0, core_halt}) begin
				c = enc_i(12'h0, 5'd0, F3_ADD, 5'd0, OP_IMM);
				for (int i = 0; i < 4; i++)
					put_byte(core_pc + i, c[8*i +: 8]);
			end
		end
		if (c[6:0] == OP_LOAD) begin
			case (c[14:12])
				F3_LB, F3_LBU: n = 1;
				F3_LH, F3_LHU: n = 2;
				F3_LW:         n = 4;
				default:       n = 0;
			endcase
			ea = regs[c[19:15]] + {{20{c[31]}}, c[31:20]};
			for (int i = 0; i < n; i++) begin
				t = ea + i;
				if (!mem_ok[t[MEM_ADDR_W-1:0]])
					put_byte(t, 8'($urandom_range(0, 255)));
			end
		end
		w = '0;
		w.mode = 1'b1;
		w.load_address = MEM_ADDR_W'($urandom_range(0, MEM_BYTES - 1));
		w.load_byte = 8'($urandom_range(0, 255));
		push_word(w, typed, typed_res);
	endtask

	function automatic logic [4:0] pick_reg();
		return ($urandom_range(0, 2) == 0) ? 5'($urandom_range(0, 31))
			: 5'($urandom_range(0, 7));
	endfunction

	function automatic logic [6:0] pick_f7();
		case ($urandom_range(0, 4))
			0:       return 7'($urandom_range(0, 127));
			1, 2:    return F7_ALT;
			default: return F7_BASE;
		endcase
	endfunction

	function automatic logic [31:0] rand_instr();
		logic [4:0] rd, rs1, rs2;
		rd = pick_reg();
		rs1 = pick_reg();
		rs2 = pick_reg();
		case ($urandom_range(0, 15))
			0:  return enc_u(20'($urandom), rd, OP_LUI);
			1:  return enc_u(20'($urandom), rd, OP_AUIPC);
			2:  return enc_j({20'($urandom_range(0, 1048575)), 1'b0}, rd);
			3:  return enc_i(12'($urandom), rs1, 3'($urandom_range(0, 7)), rd, OP_JALR);
			4:  return enc_b({12'($urandom_range(0, 4095)), 1'b0}, rs2, rs1,
				3'($urandom_range(0, 7)));
			5:  return enc_i(12'($urandom), rs1, 3'($urandom_range(0, 7)), rd, OP_LOAD);
			6:  return enc_s(12'($urandom), rs2, rs1, 3'($urandom_range(0, 3)));
			7, 8: begin
				if ($urandom_range(0, 1))
					return enc_i({pick_f7(), 5'($urandom)}, rs1, F3_SR, rd, OP_IMM);
				return enc_i(12'($urandom), rs1, 3'($urandom_range(0, 7)), rd, OP_IMM);
			end
			9, 10: return enc_r(pick_f7(), rs2, rs1, 3'($urandom_range(0, 7)), rd, OP_REG);
			11: return {25'($urandom), 7'($urandom)};
			12: return $urandom;
			default: return enc_i(12'($urandom), 5'd0, F3_ADD, rd, OP_IMM);
		endcase
	endfunction

	task automatic run_random(int upto);
		logic [31:0] c;
		bool_ok_t    ok;
		while (sent < upto) begin
			ok = mem_ok[core_pc[MEM_ADDR_W-1:0]] && mem_ok[18'(core_pc + 1)]
				&& mem_ok[18'(core_pc + 2)] && mem_ok[18'(core_pc + 3)];
			case ($urandom_range(0, 9))
				0:       put_byte($urandom, 8'($urandom_range(0, 255)));
				1, 2:    exec_one(32'h0, !ok, 1'b0);
				default: exec_one(rand_instr(), 1'b1, 1'b0);
			endcase
		end
		in_valid <= 1'b0;
	endtask

	task automatic settle_and_cfg(logic [HALT_W-1:0] v);
		in_valid <= 1'b0;
		while (result_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		core_halt = v;
	endtask

	task automatic build_rows();
		dir_rows.push_back('{enc_i(12'hFFF, 5'd0, F3_ADD, 5'd1, OP_IMM), 1'b1,
			mk_out(32'd0, 32'd4, 1'b1, 5'd1, 32'hFFFF_FFFF)});
		dir_rows.push_back('{enc_u(20'h80000, 5'd2, OP_LUI), 1'b1,
			mk_out(32'd4, 32'd8, 1'b1, 5'd2, 32'h8000_0000)});
		dir_rows.push_back('{enc_i(12'd5, 5'd1, F3_ADD, 5'd0, OP_IMM), 1'b1,
			mk_out(32'd8, 32'd12, 1'b0, 5'd0, 32'd0)});
		dir_rows.push_back('{32'h0000_007F, 1'b1, mk_out(32'd12, 32'd16, 1'b0, 5'd0, 32'd0)});
		dir_rows.push_back('{enc_i(12'h7FF, 5'd0, F3_ADD, 5'd3, OP_IMM), 1'b1,
			mk_out(32'd16, 32'd20, 1'b1, 5'd3, 32'h0000_07FF)});
		dir_rows.push_back('{enc_i(12'h0A5, 5'd0, F3_ADD, 5'd10, OP_IMM), 1'b0, '0});
		for (int f = 0; f < 8; f++)
			dir_rows.push_back('{enc_r(f == 0 ? F7_ALT : F7_BASE, 5'd3, 5'd2, 3'(f),
				5'(4 + f), OP_REG), 1'b0, '0});
		dir_rows.push_back('{enc_r(F7_ALT, 5'd3, 5'd2, F3_SR, 5'd12, OP_REG), 1'b0, '0});
		dir_rows.push_back('{enc_r(7'h01, 5'd3, 5'd2, F3_ADD, 5'd13, OP_REG), 1'b0, '0});
		dir_rows.push_back('{enc_i({F7_ALT, 5'd31}, 5'd2, F3_SR, 5'd14, OP_IMM), 1'b0, '0});
		dir_rows.push_back('{enc_i(12'h800, 5'd1, F3_SLTU, 5'd15, OP_IMM), 1'b0, '0});
		dir_rows.push_back('{enc_u(20'hFFFFF, 5'd16, OP_AUIPC), 1'b0, '0});
		dir_rows.push_back('{enc_s(12'h100, 5'd2, 5'd0, F3_SW), 1'b0, '0});
		dir_rows.push_back('{enc_s(12'h104, 5'd1, 5'd0, F3_SH), 1'b0, '0});
		dir_rows.push_back('{enc_i(12'h103, 5'd0, F3_LB, 5'd17, OP_LOAD), 1'b0, '0});
		dir_rows.push_back('{enc_i(12'h102, 5'd0, F3_LH, 5'd18, OP_LOAD), 1'b0, '0});
		dir_rows.push_back('{enc_i(12'h104, 5'd0, F3_LHU, 5'd19, OP_LOAD), 1'b0, '0});
		dir_rows.push_back('{enc_i(12'h103, 5'd0, F3_LBU, 5'd20, OP_LOAD), 1'b0, '0});
		dir_rows.push_back('{enc_i(12'h101, 5'd0, F3_LW, 5'd21, OP_LOAD), 1'b0, '0});
		dir_rows.push_back('{enc_i(12'h100, 5'd0, 3'd3, 5'd22, OP_LOAD), 1'b0, '0});
		for (int f = 0; f < 8; f++)
			dir_rows.push_back('{enc_b(13'd8, 5'd1, 5'd2, 3'(f)), 1'b0, '0});
		dir_rows.push_back('{enc_j(21'h1FFFF0, 5'd23), 1'b0, '0});
		dir_rows.push_back('{enc_i(12'd1, 5'd3, 3'd0, 5'd24, OP_JALR), 1'b0, '0});
	endtask

	always @(posedge clk) begin
		out_t e;
		if (out_valid && out_ready) begin
			rx_cnt <= rx_cnt + 1;
			if (result_q.size() == 0) begin
				err_cnt <= err_cnt + 1;
				if (err_cnt < 10)
					$display("unexpected result word %h", out_data);
			end else begin
				e = result_q.pop_front();
				if (out_data.instr_pc !== e.instr_pc || out_data.next_pc !== e.next_pc
					|| out_data.reg_written !== e.reg_written
					|| out_data.reg_index !== e.reg_index
					|| out_data.reg_value !== e.reg_value
					|| out_data.halted !== e.halted || out_data.exit_code !== e.exit_code) begin
					err_cnt <= err_cnt + 1;
					if (err_cnt < 10)
						$display("mismatch: exp pc=%h npc=%h wr=%b rd=%0d val=%h h=%b code=%h",
							e.instr_pc, e.next_pc, e.reg_written, e.reg_index, e.reg_value,
							e.halted, e.exit_code,
							" got pc=%h npc=%h wr=%b rd=%0d val=%h h=%b code=%h",
							out_data.instr_pc, out_data.next_pc,
							out_data.reg_written, out_data.reg_index, out_data.reg_value,
							out_data.halted, out_data.exit_code);
				end
			end
		end
	end

	initial begin
		int  hold_left;
		bit  long_done;
		int  cyc;
		hold_left = 0;
		long_done = 1'b0;
		cyc = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!long_done && rx_cnt >= 300) begin
				long_done = 1'b1;
				hold_left = 400;
				out_ready <= 1'b0;
			end else begin
				case ((cyc / 97) % 3)
					0:       out_ready <= 1'b1;
					1:       out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin
		logic [HALT_W-1:0] h;
		logic [19:0]       hi;
		logic [11:0]       lo;
		in_t               w;
		for (int i = 0; i < NUM_REGS; i++)
			regs[i] = '0;
		for (int i = 0; i < MEM_BYTES; i++) begin
			mem_b[i] = '0;
			mem_ok[i] = 1'b0;
		end
		build_rows();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			exec_one(dir_rows[i].word, 1'b1, 1'b0, dir_rows[i].typed, dir_rows[i].res);
		put_byte(32'h3FFFF, 8'hFF);

		settle_and_cfg('0);
		run_random(sent + 400);
		settle_and_cfg('1);
		run_random(sent + 400);
		settle_and_cfg(HALT_W'($urandom_range(0, MEM_BYTES - 1)));
		run_random(sent + 400);

		h = HALT_W'($urandom_range(0, MEM_BYTES - 1));
		settle_and_cfg(h);
		run_random(sent + 150);
		hi = 20'((32'(h) + 32'h800) >> 12);
		lo = h[11:0];
		exec_one(enc_u(hi, 5'd5, OP_LUI), 1'b1, 1'b0);
		exec_one(enc_i(lo, 5'd5, F3_ADD, 5'd5, OP_IMM), 1'b1, 1'b0);
		exec_one(enc_i(12'($urandom), 5'd0, F3_ADD, 5'd10, OP_IMM), 1'b1, 1'b0);
		exec_one(enc_s(12'h0, 5'd1, 5'd5, F3_SB), 1'b1, 1'b1);
		for (int i = 0; i < 6; i++) begin
			w.mode = i[0];
			w.load_address = MEM_ADDR_W'($urandom_range(0, MEM_BYTES - 1));
			w.load_byte = 8'($urandom_range(0, 255));
			push_word(w);
		end
		in_valid <= 1'b0;

		while (result_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (err_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/rvc_pkg.sv
sv/rvc_ram.sv
sv/rvc_ctrl.sv
sv/rvc_dp.sv
sv/rv32i_integer_core.sv
tb/sv/tb.sv
